@@ hdl/tlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpq_pkg
// shared types, widths and codes of the two-level priority queue
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int TLPQ_LIST_DEPTH = 16;
  localparam int TLPQ_DATA_W     = 32;

  typedef logic signed [TLPQ_DATA_W-1:0] word_t;

  // operation codes of a request
  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // run the captured request and load the result register
  } tlpq_cmd_t;

endpackage

@@ hdl/tlpq_if.sv @@
// ----------------------------------------------------------------------------
// tlpq_in_if / tlpq_out_if
// valid/ready channels of the two-level priority queue
// ----------------------------------------------------------------------------
interface tlpq_in_if import tlpq_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  word_t item_value;
  word_t item_priority;

  modport source (output valid, func, item_value, item_priority, input ready);
  modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

interface tlpq_out_if import tlpq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   out_value;
  word_t   out_priority;
  logic    from_urgent;

  modport source (output valid, status, out_value, out_priority, from_urgent,
                  input ready);
  modport sink   (input valid, status, out_value, out_priority, from_urgent,
                  output ready);
endinterface

@@ hdl/two_level_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// two_level_priority_queue_top
// two sorted priority lists, urgent and normal, behind valid/ready channels
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request: func (enqueue or dequeue), item_value and
//   item_priority. every request gives exactly one result on out_ch with
//   status, out_value, out_priority and from_urgent.
//   cfg_we/cfg_wdata write urgent_threshold; write it only while idle.
// sequence:
//   a request is captured while idle and run in the execute state, where at
//   most one list inserts or pops, in parallel across its shift cells, and the
//   result register loads. a new request is taken only after the last one has
//   run, set by the capture plus execute sequence of the controller.
// stall:
//   the result register holds while out_ch.ready is low; a new request is
//   still taken, and waits in the execute step until the result is taken.
// reset:
//   rst_n (synchronous, active low) empties both lists, clears the
//   threshold to zero and drops any pending result. no clearing pass.
// ----------------------------------------------------------------------------
module two_level_priority_queue_top import tlpq_pkg::*; #(
  parameter int LIST_DEPTH = TLPQ_LIST_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  tlpq_in_if.sink    in_ch,
  tlpq_out_if.source out_ch,
  input  logic       cfg_we,
  input  word_t      cfg_wdata
);

  tlpq_cmd_t cmd;   // sequencer commands into the datapath

  // controller: owns handshakes and the result valid flag
  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: request capture, threshold, both lists, result register
  tlpq_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_ch.func),
    .in_item_value    (in_ch.item_value),
    .in_item_priority (in_ch.item_priority),
    .res_status       (out_ch.status),
    .res_value        (out_ch.out_value),
    .res_priority     (out_ch.out_priority),
    .res_urgent       (out_ch.from_urgent)
  );

endmodule

@@ hdl/tlpq_list.sv @@
// ----------------------------------------------------------------------------
// tlpq_list
// sorted list as a row of shift cells, insert or pop moves all cells in parallel
// ----------------------------------------------------------------------------
module tlpq_list import tlpq_pkg::*; #(
  parameter int DEPTH = TLPQ_LIST_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ins,
  input  logic  pop,
  input  word_t ins_val,
  input  word_t ins_pri,
  output word_t head_val,
  output word_t head_pri,
  output logic  empty,
  output logic  full
);

  localparam int CW = $clog2(DEPTH + 1);

  word_t          val_r   [DEPTH];
  word_t          pri_r   [DEPTH];
  word_t          val_nxt [DEPTH];
  word_t          pri_nxt [DEPTH];
  logic [DEPTH-1:0] keep;   // cell holds an entry that stays ahead of the new one
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign keep[i] = (CW'(i) < cnt_r) && (pri_r[i] >= ins_pri);

    if (i == 0) begin : g_first
      always_comb begin
        val_nxt[i] = val_r[i];
        pri_nxt[i] = pri_r[i];
        if (ins && !keep[i]) begin
          val_nxt[i] = ins_val;
          pri_nxt[i] = ins_pri;
        end else if (pop) begin
          val_nxt[i] = val_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
      end
    end else begin : g_rest
      always_comb begin
        val_nxt[i] = val_r[i];
        pri_nxt[i] = pri_r[i];
        if (ins && !keep[i]) begin
          // new entry lands right behind the last entry it may not pass
          val_nxt[i] = keep[i-1] ? ins_val : val_r[i-1];
          pri_nxt[i] = keep[i-1] ? ins_pri : pri_r[i-1];
        end else if (pop && (i < DEPTH - 1)) begin
          val_nxt[i] = val_r[(i < DEPTH - 1) ? i + 1 : i];
          pri_nxt[i] = pri_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins)      cnt_nxt = cnt_r + CW'(1);
    else if (pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_val = val_r[0];
  assign head_pri = pri_r[0];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));

endmodule

@@ hdl/tlpq_datapath.sv @@
// ----------------------------------------------------------------------------
// tlpq_datapath
// request capture, threshold register, the two lists and the result register
// ----------------------------------------------------------------------------
module tlpq_datapath import tlpq_pkg::*; #(
  parameter int LIST_DEPTH = TLPQ_LIST_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tlpq_cmd_t cmd,
  input  logic      cfg_we,
  input  word_t     cfg_wdata,
  input  func_t     in_func,
  input  word_t     in_item_value,
  input  word_t     in_item_priority,
  output status_t   res_status,
  output word_t     res_value,
  output word_t     res_priority,
  output logic      res_urgent
);

  word_t   thr_r;
  func_t   op_func_r;
  word_t   op_val_r;
  word_t   op_pri_r;
  status_t res_status_r, res_status_nxt;
  word_t   res_val_r, res_val_nxt;
  word_t   res_pri_r, res_pri_nxt;
  logic    res_urg_r, res_urg_nxt;

  logic  u_ins, u_pop, u_empty, u_full;
  logic  n_ins, n_pop, n_empty, n_full;
  word_t u_head_val, u_head_pri, n_head_val, n_head_pri;
  logic  is_urgent;

  assign is_urgent = (op_pri_r > thr_r);

  always_comb begin
    u_ins          = 1'b0;
    u_pop          = 1'b0;
    n_ins          = 1'b0;
    n_pop          = 1'b0;
    res_status_nxt = STAT_OK;
    res_val_nxt    = '0;
    res_pri_nxt    = '0;
    res_urg_nxt    = 1'b0;
    case (op_func_r)
      FUNC_ENQ: begin
        res_urg_nxt = is_urgent;
        if (is_urgent) begin
          if (u_full) res_status_nxt = STAT_FULL;
          else        u_ins = cmd.exec;
        end else begin
          if (n_full) res_status_nxt = STAT_FULL;
          else        n_ins = cmd.exec;
        end
      end
      FUNC_DEQ: begin
        if (!u_empty) begin
          u_pop       = cmd.exec;
          res_val_nxt = u_head_val;
          res_pri_nxt = u_head_pri;
          res_urg_nxt = 1'b1;
        end else if (!n_empty) begin
          n_pop       = cmd.exec;
          res_val_nxt = n_head_val;
          res_pri_nxt = n_head_pri;
        end else begin
          res_status_nxt = STAT_EMPTY;
        end
      end
      default: res_status_nxt = STAT_OK;
    endcase
  end

  tlpq_list #(.DEPTH(LIST_DEPTH)) u_urgent (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (u_ins),
    .pop      (u_pop),
    .ins_val  (op_val_r),
    .ins_pri  (op_pri_r),
    .head_val (u_head_val),
    .head_pri (u_head_pri),
    .empty    (u_empty),
    .full     (u_full)
  );

  tlpq_list #(.DEPTH(LIST_DEPTH)) u_normal (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (n_ins),
    .pop      (n_pop),
    .ins_val  (op_val_r),
    .ins_pri  (op_pri_r),
    .head_val (n_head_val),
    .head_pri (n_head_pri),
    .empty    (n_empty),
    .full     (n_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func_r <= in_func;
      op_val_r  <= in_item_value;
      op_pri_r  <= in_item_priority;
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_val_r    <= res_val_nxt;
      res_pri_r    <= res_pri_nxt;
      res_urg_r    <= res_urg_nxt;
    end
  end

  assign res_status   = res_status_r;
  assign res_value    = res_val_r;
  assign res_priority = res_pri_r;
  assign res_urgent   = res_urg_r;

endmodule

@@ hdl/tlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpq_ctrl
// request sequencer and result valid flag
// ----------------------------------------------------------------------------
module tlpq_ctrl import tlpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tlpq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_free;

  // result register is free when empty or being drained this cycle
  assign res_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state_r == ST_EXEC) && res_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd.load) state_nxt = ST_EXEC;
      ST_EXEC: if (cmd.exec) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sim/two_level_priority_queue_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_priority_queue_top_tb
// self-checking bench for the two-level sorted priority queue: a table of
// directed requests, a long output hold that backs up the input, then random
// request bursts under several urgent thresholds, scored against the
// results of typed table rows and otherwise against an in-bench copy of
// both sorted lists
module two_level_priority_queue_top_tb;
  import tlpq_pkg::*;

  localparam int LIST_DEPTH     = TLPQ_LIST_DEPTH;
  localparam int NORMAL_LIST    = 0;
  localparam int URGENT_LIST    = 1;
  localparam int N_DIRECTED     = 16;
  localparam int PHASE_ITEMS    = 260;
  localparam int PRESSURE_ITEMS = 24;
  localparam int PRESSURE_HOLD  = 120;
  // quiet margin before a threshold write and at the end of the run
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_LIMIT    = 5000;

  // one result as the block reports it
  typedef struct packed {
    status_t status;
    word_t   value;
    word_t   prio;
    logic    urgent;
  } pq_result_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    func_t      op;
    word_t      value;
    word_t      prio;
    bit         typed;
    pq_result_t want;
  } step_row_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  word_t cfg_wdata;

  tlpq_in_if  in_ch ();
  tlpq_out_if out_ch ();

  two_level_priority_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the threshold and both sorted lists
  word_t threshold_model = '0;
  word_t list_val [2][LIST_DEPTH];
  word_t list_pri [2][LIST_DEPTH];
  int    list_cnt [2] = '{0, 0};

  // results owed by the block, oldest first
  pq_result_t pending_results [$];

  int error_count     = 0;
  int requests_sent   = 0;
  int thresholds_used = 0;
  int n_ok            = 0;
  int n_full          = 0;
  int n_empty         = 0;
  int n_urgent        = 0;
  int idle_cycles     = 0;
  // output hold handshake between stimulus and receiver
  int hold_asked      = 0;
  int holds_begun     = 0;

  // threshold 0 after reset: max and 1 go urgent, 0 / -1 / min go normal
  step_row_t directed_steps [N_DIRECTED] = '{
    // nothing stored yet
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b1, '{STAT_EMPTY, 32'h0, 32'h0, 1'b0}},
    '{FUNC_ENQ, 32'h7fffffff, 32'h7fffffff, 1'b1, '{STAT_OK, 32'h0, 32'h0, 1'b1}},
    '{FUNC_ENQ, 32'h80000000, 32'h80000000, 1'b1, '{STAT_OK, 32'h0, 32'h0, 1'b0}},
    // priority equal to the threshold stays normal
    '{FUNC_ENQ, 32'h00000000, 32'h00000000, 1'b1, '{STAT_OK, 32'h0, 32'h0, 1'b0}},
    '{FUNC_ENQ, 32'hffffffff, 32'h00000001, 1'b1, '{STAT_OK, 32'h0, 32'h0, 1'b1}},
    // ties land behind the stored entries; -1 goes in between 0 and min
    '{FUNC_ENQ, 32'h5a5a5a5a, 32'h00000001, 1'b0, '0},
    '{FUNC_ENQ, 32'ha5a5a5a5, 32'h00000000, 1'b0, '0},
    '{FUNC_ENQ, 32'h12345678, 32'hffffffff, 1'b0, '0},
    // urgent head first, then drain everything
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b1,
      '{STAT_OK, 32'h7fffffff, 32'h7fffffff, 1'b1}},
    '{FUNC_DEQ, 32'hdeadbeef, 32'h7fffffff, 1'b0, '0},
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b0, '0},
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b0, '0},
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b0, '0},
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b0, '0},
    '{FUNC_DEQ, 32'h0, 32'h0, 1'b1,
      '{STAT_OK, 32'h80000000, 32'h80000000, 1'b0}},
    '{FUNC_DEQ, 32'hffffffff, 32'hffffffff, 1'b1, '{STAT_EMPTY, 32'h0, 32'h0, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run one request through the shadow lists and return what the block owes
  function automatic pq_result_t apply_request(func_t op, word_t value, word_t prio);
    pq_result_t res;
    int         sel;
    int         i;
    res = '{STAT_OK, 32'h0, 32'h0, 1'b0};
    if (op == FUNC_ENQ) begin
      // signed compare, strictly above goes urgent
      sel = (prio > threshold_model) ? URGENT_LIST : NORMAL_LIST;
      res.urgent = (sel == URGENT_LIST);
      if (list_cnt[sel] >= LIST_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        // walk up past every lower priority, stop behind equal ones
        i = list_cnt[sel];
        while (i > 0 && prio > list_pri[sel][i-1]) begin
          list_val[sel][i] = list_val[sel][i-1];
          list_pri[sel][i] = list_pri[sel][i-1];
          i--;
        end
        list_val[sel][i] = value;
        list_pri[sel][i] = prio;
        list_cnt[sel]++;
      end
    end else begin
      if (list_cnt[URGENT_LIST] > 0) begin
        sel = URGENT_LIST;
      end else if (list_cnt[NORMAL_LIST] > 0) begin
        sel = NORMAL_LIST;
      end else begin
        sel = -1;
      end
      if (sel < 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.value  = list_val[sel][0];
        res.prio   = list_pri[sel][0];
        res.urgent = (sel == URGENT_LIST);
        for (i = 1; i < list_cnt[sel]; i++) begin
          list_val[sel][i-1] = list_val[sel][i];
          list_pri[sel][i-1] = list_pri[sel][i];
        end
        list_cnt[sel]--;
      end
    end
    return res;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // priorities clustered near the threshold and near zero to force ties,
  // plus corners and full-range values
  function automatic word_t pick_priority();
    word_t corner [5];
    int    roll;
    corner = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, threshold_model};
    roll   = $urandom_range(0, 9);
    if (roll < 4) return threshold_model + $urandom_range(0, 6) - 3;
    if (roll == 4) return corner[$urandom_range(0, 4)];
    if (roll < 7) return $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  // offer one request after gap idle cycles, hold it until taken, then
  // book the result it owes; valid is left high for a follow-on request
  task automatic send_req(input func_t op, input word_t value, input word_t prio,
                          input int gap, input bit typed, input pq_result_t want);
    pq_result_t predicted;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= op;
    in_ch.item_value    <= value;
    in_ch.item_priority <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // the shadow lists advance on every request, typed rows included
    predicted = apply_request(op, value, prio);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // threshold only changes with the block idle and every result collected
  task automatic set_threshold(input word_t thr);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we          <= 1'b0;
    threshold_model = thr;
    thresholds_used++;
  endtask

  // random bursts: enqueue-heavy bursts fill lists, dequeue-heavy ones
  // drain them, balanced ones churn the sort order
  task automatic run_phase(input word_t thr, input int count);
    int    left;
    int    burst;
    int    enq_pct;
    int    k;
    int    gap;
    bit    gapless;
    func_t op;
    set_threshold(thr);
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      for (k = 0; k < burst; k++) begin
        op  = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        gap = gapless ? 0 : pick_gap();
        send_req(op, $urandom, pick_priority(), gap, 1'b0, '0);
      end
      left -= burst;
    end
  endtask

  // receiver: random ready pattern, plus a long hold when asked
  initial begin
    int run_len;
    int roll;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_begun != hold_asked) begin
        // long hold so the result register and the input both back up
        holds_begun++;
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          out_ch.ready <= 1'b1;
          run_len = $urandom_range(20, 60);
        end else if (roll < 55) begin
          out_ch.ready <= 1'b1;
          run_len = $urandom_range(1, 8);
        end else if (roll < 95) begin
          out_ch.ready <= 1'b0;
          run_len = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          run_len = $urandom_range(10, 40);
        end
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // scoreboard: every taken result against the oldest one owed
  always @(posedge clk) begin : check_results
    pq_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d value %0d priority %0d",
               out_ch.status, out_ch.out_value, out_ch.out_priority);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_ch.out_value);
          error_count++;
        end
        if (out_ch.out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, out_ch.out_priority);
          error_count++;
        end
        if (out_ch.from_urgent !== want.urgent) begin
          $error("from_urgent: expected %0d, got %0d", want.urgent, out_ch.from_urgent);
          error_count++;
        end
        case (want.status)
          STAT_OK:    n_ok++;
          STAT_FULL:  n_full++;
          default:    n_empty++;
        endcase
        if (want.urgent) n_urgent++;
      end
    end
  end

  // watchdog: too long with no request and no result moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int idx;
    int drain_wait;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_ENQ;
    in_ch.item_value    <= '0;
    in_ch.item_priority <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, threshold still at its reset value
    for (idx = 0; idx < N_DIRECTED; idx++) begin
      send_req(directed_steps[idx].op, directed_steps[idx].value,
               directed_steps[idx].prio, pick_gap(), directed_steps[idx].typed,
               directed_steps[idx].want);
    end

    // backpressure: hold the output at the start of a back-to-back enqueue
    // burst that overfills the urgent list, then drain it past empty
    in_ch.valid <= 1'b0;
    hold_asked++;
    while (holds_begun != hold_asked) @(posedge clk);
    for (idx = 0; idx < PRESSURE_ITEMS; idx++) begin
      send_req(FUNC_ENQ, $urandom, $urandom_range(1, 40), 0, 1'b0, '0);
    end
    for (idx = 0; idx < PRESSURE_ITEMS; idx++) begin
      send_req(FUNC_DEQ, $urandom, $urandom, pick_gap(), 1'b0, '0);
    end

    // random phases: both threshold extremes, zero, and a few others
    run_phase(32'sh7fffffff, PHASE_ITEMS);
    run_phase(32'sh80000000, PHASE_ITEMS);
    run_phase(32'sd0, PHASE_ITEMS);
    run_phase($urandom, PHASE_ITEMS);
    run_phase(-32'sd100, PHASE_ITEMS);
    run_phase(32'sd1000, PHASE_ITEMS);

    // wind down: collect what is owed, then wait out the settle margin
    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("%0d requests: %0d ok, %0d dropped on a full list, %0d on empty lists, %0d urgent",
             requests_sent, n_ok, n_full, n_empty, n_urgent);
    $display("%0d threshold settings, one output hold of %0d cycles",
             thresholds_used, PRESSURE_HOLD);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tlpq_pkg.sv
hdl/tlpq_if.sv
hdl/tlpq_list.sv
hdl/tlpq_datapath.sv
hdl/tlpq_ctrl.sv
hdl/two_level_priority_queue_top.sv
sim/two_level_priority_queue_top_tb.sv
